>>> hdl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property sampled on the block clock, off during reset
`define SLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sle assertion failed");

// same-cycle implication
`define SLE_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("sle implication failed");

`endif

>>> hdl/sle_pkg.sv
package sle_pkg;

  localparam int unsigned DEPTH  = 32;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned FUNC_W = 4;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned PW     = (POS_W > CW) ? POS_W : CW;

  localparam logic [FUNC_W-1:0] F_APPEND     = 4'd0;
  localparam logic [FUNC_W-1:0] F_PREPEND    = 4'd1;
  localparam logic [FUNC_W-1:0] F_DROP_LAST  = 4'd2;
  localparam logic [FUNC_W-1:0] F_DROP_FIRST = 4'd3;
  localparam logic [FUNC_W-1:0] F_INSERT_AT  = 4'd4;
  localparam logic [FUNC_W-1:0] F_DELETE_AT  = 4'd5;
  localparam logic [FUNC_W-1:0] F_DELETE_VAL = 4'd6;
  localparam logic [FUNC_W-1:0] F_FIND       = 4'd7;
  localparam logic [FUNC_W-1:0] F_SORT       = 4'd8;
  localparam logic [FUNC_W-1:0] F_REVERSE    = 4'd9;
  localparam logic [FUNC_W-1:0] F_CLEAR      = 4'd10;
  localparam logic [FUNC_W-1:0] F_DUMP       = 4'd11;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {WS_VALUE, WS_RDATA, WS_HOLD} wsel_e;
  typedef enum logic [1:0] {CO_NONE, CO_INC, CO_DEC, CO_CLR} cop_e;

  typedef struct packed {
    logic             take;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    wsel_e            wr_sel;
    logic             cap_a;
    cop_e             cnt_op;
    logic             emit;
    logic [ST_W-1:0]  st;
    logic [IDX_W-1:0] idx;
    logic             elem_rd;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  pos;
    logic [CW-1:0]     cnt;
    logic              eq;
    logic              gt;
    logic              out_free;
  } stat_t;

endpackage

>>> hdl/sle_dpath.sv
`include "assert_macros.svh"

module sle_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sle_pkg::cmd_t                      cmd_i,
  output sle_pkg::stat_t                     stat_o,
  input  logic                               in_valid_i,
  input  logic [sle_pkg::FUNC_W-1:0]         func_i,
  input  logic [sle_pkg::POS_W-1:0]          pos_i,
  input  logic signed [sle_pkg::VAL_W-1:0]   value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [sle_pkg::ST_W-1:0]           status_o,
  output logic [sle_pkg::IDX_W-1:0]          index_o,
  output logic signed [sle_pkg::VAL_W-1:0]   element_o,
  output logic [sle_pkg::CNT_W-1:0]          count_o,
  output logic                               last_o
);
  import sle_pkg::*;

  logic [VAL_W-1:0]        mem_q [DEPTH];
  logic [VAL_W-1:0]        rdata_q;
  logic [VAL_W-1:0]        a_q;
  logic [VAL_W-1:0]        wdata;
  logic [FUNC_W-1:0]       func_q;
  logic [POS_W-1:0]        pos_q;
  logic [VAL_W-1:0]        value_q;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    out_valid_q;
  logic                    out_free;
  logic [ST_W-1:0]         status_q;
  logic [IDX_W-1:0]        index_q;
  logic [VAL_W-1:0]        element_q;
  logic [CNT_W-1:0]        count_q;
  logic                    last_q;

  always_comb begin
    case (cmd_i.wr_sel)
      WS_VALUE: wdata = value_q;
      WS_RDATA: wdata = rdata_q;
      WS_HOLD:  wdata = a_q;
      default:  wdata = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_addr];
    end
    if (cmd_i.cap_a) begin
      a_q <= rdata_q;
    end
    if (in_valid_i && cmd_i.take) begin
      func_q  <= func_i;
      pos_q   <= pos_i;
      value_q <= value_i;
    end
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CO_INC:  cnt_d = cnt_q + 1'b1;
      CO_DEC:  cnt_d = cnt_q - 1'b1;
      CO_CLR:  cnt_d = '0;
      default: cnt_d = cnt_q;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q  <= cmd_i.st;
      index_q   <= cmd_i.idx;
      element_q <= cmd_i.elem_rd ? rdata_q : '0;
      count_q   <= CNT_W'(cnt_q);
      last_q    <= cmd_i.last;
    end
  end

  always_comb begin
    stat_o          = '0;
    stat_o.in_valid = in_valid_i;
    stat_o.func     = func_q;
    stat_o.pos      = pos_q;
    stat_o.cnt      = cnt_q;
    stat_o.eq       = (rdata_q == value_q);
    stat_o.gt       = ($signed(a_q) > $signed(rdata_q));
    stat_o.out_free = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign index_o     = index_q;
  assign element_o   = element_q;
  assign count_o     = count_q;
  assign last_o      = last_q;

  `SLE_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH))
  `SLE_ASSERT_IMPL(a_emit_free, cmd_i.emit, out_free)
  `SLE_ASSERT_IMPL(a_no_inc_full, cmd_i.cnt_op == CO_INC, cnt_q < CW'(DEPTH))

endmodule

>>> hdl/sle_ctrl.sv
`include "assert_macros.svh"

module sle_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sle_pkg::stat_t stat_i,
  output sle_pkg::cmd_t  cmd_o
);
  import sle_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_INS_RD   = 5'd2;
  localparam logic [4:0] S_INS_WR   = 5'd3;
  localparam logic [4:0] S_DEL_RD   = 5'd4;
  localparam logic [4:0] S_DEL_WR   = 5'd5;
  localparam logic [4:0] S_FIND_RD  = 5'd6;
  localparam logic [4:0] S_FIND_CMP = 5'd7;
  localparam logic [4:0] S_SORT_CHK = 5'd8;
  localparam logic [4:0] S_SORT_RB  = 5'd9;
  localparam logic [4:0] S_SORT_CMP = 5'd10;
  localparam logic [4:0] S_SORT_WB  = 5'd11;
  localparam logic [4:0] S_REV_CHK  = 5'd12;
  localparam logic [4:0] S_REV_RB   = 5'd13;
  localparam logic [4:0] S_REV_W1   = 5'd14;
  localparam logic [4:0] S_REV_W2   = 5'd15;
  localparam logic [4:0] S_DMP_RD   = 5'd16;
  localparam logic [4:0] S_DMP_OUT  = 5'd17;
  localparam logic [4:0] S_DONE     = 5'd18;

  logic [4:0]       state_q, state_d;
  logic [CW-1:0]    i_q, i_d, j_q, j_d, lim_q, lim_d;
  logic [ST_W-1:0]  st_q, st_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CW-1:0]    im1, ip1, jp1;
  logic             full, empty;

  assign im1   = i_q - 1'b1;
  assign ip1   = i_q + 1'b1;
  assign jp1   = j_q + 1'b1;
  assign full  = (stat_i.cnt == CW'(DEPTH));
  assign empty = (stat_i.cnt == '0);

  always_comb begin
    cmd_o        = '0;
    cmd_o.wr_sel = WS_VALUE;
    cmd_o.cnt_op = CO_NONE;
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    lim_d        = lim_q;
    st_d         = st_q;
    idx_d        = idx_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (stat_i.in_valid) state_d = S_DISP;
      end
      S_DISP: begin
        st_d    = ST_OK;
        idx_d   = '0;
        state_d = S_DONE;
        case (stat_i.func)
          F_APPEND: begin
            if (full) st_d = ST_FULL;
            else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_addr = stat_i.cnt[AW-1:0];
              cmd_o.cnt_op  = CO_INC;
            end
          end
          F_PREPEND: begin
            if (full) st_d = ST_FULL;
            else begin
              i_d     = stat_i.cnt;
              j_d     = '0;
              state_d = S_INS_RD;
            end
          end
          F_INSERT_AT: begin
            if (full) st_d = ST_FULL;
            else if (PW'(stat_i.pos) > PW'(stat_i.cnt)) st_d = ST_BADPOS;
            else begin
              i_d     = stat_i.cnt;
              j_d     = CW'(stat_i.pos);
              state_d = S_INS_RD;
            end
          end
          F_DROP_LAST: begin
            if (empty) st_d = ST_EMPTY;
            else cmd_o.cnt_op = CO_DEC;
          end
          F_DROP_FIRST: begin
            if (empty) st_d = ST_EMPTY;
            else begin
              i_d     = '0;
              state_d = S_DEL_RD;
            end
          end
          F_DELETE_AT: begin
            if (PW'(stat_i.pos) >= PW'(stat_i.cnt)) st_d = ST_BADPOS;
            else begin
              i_d     = CW'(stat_i.pos);
              state_d = S_DEL_RD;
            end
          end
          F_DELETE_VAL, F_FIND: begin
            i_d     = '0;
            state_d = S_FIND_RD;
          end
          F_SORT: begin
            j_d     = '0;
            lim_d   = empty ? '0 : stat_i.cnt - 1'b1;
            state_d = S_SORT_CHK;
          end
          F_REVERSE: begin
            i_d     = '0;
            j_d     = empty ? '0 : stat_i.cnt - 1'b1;
            state_d = S_REV_CHK;
          end
          F_CLEAR: cmd_o.cnt_op = CO_CLR;
          F_DUMP: begin
            if (empty) st_d = ST_EMPTY;
            else begin
              i_d     = '0;
              state_d = S_DMP_RD;
            end
          end
          default: ;
        endcase
      end
      // open a gap: move entries up from the tail down to the target slot
      S_INS_RD: begin
        if (i_q == j_q) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = i_q[AW-1:0];
          cmd_o.wr_sel  = WS_VALUE;
          cmd_o.cnt_op  = CO_INC;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = im1[AW-1:0];
          state_d       = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = i_q[AW-1:0];
        cmd_o.wr_sel  = WS_RDATA;
        i_d           = im1;
        state_d       = S_INS_RD;
      end
      // close a gap: move entries down toward the head
      S_DEL_RD: begin
        if (ip1 >= stat_i.cnt) begin
          cmd_o.cnt_op = CO_DEC;
          state_d      = S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = ip1[AW-1:0];
          state_d       = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = i_q[AW-1:0];
        cmd_o.wr_sel  = WS_RDATA;
        i_d           = ip1;
        state_d       = S_DEL_RD;
      end
      S_FIND_RD: begin
        if (i_q >= stat_i.cnt) begin
          st_d    = ST_NOTFOUND;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = i_q[AW-1:0];
          state_d       = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (stat_i.eq) begin
          if (stat_i.func == F_FIND) begin
            idx_d   = IDX_W'(i_q);
            state_d = S_DONE;
          end else begin
            state_d = S_DEL_RD;
          end
        end else begin
          i_d     = ip1;
          state_d = S_FIND_RD;
        end
      end
      // bubble pass: compare j and j+1, lim shrinks after each pass
      S_SORT_CHK: begin
        if (lim_q == '0) begin
          state_d = S_DONE;
        end else if (j_q == lim_q) begin
          lim_d = lim_q - 1'b1;
          j_d   = '0;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = j_q[AW-1:0];
          state_d       = S_SORT_RB;
        end
      end
      S_SORT_RB: begin
        cmd_o.cap_a   = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = jp1[AW-1:0];
        state_d       = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (stat_i.gt) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = j_q[AW-1:0];
          cmd_o.wr_sel  = WS_RDATA;
          state_d       = S_SORT_WB;
        end else begin
          j_d     = jp1;
          state_d = S_SORT_CHK;
        end
      end
      S_SORT_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = jp1[AW-1:0];
        cmd_o.wr_sel  = WS_HOLD;
        j_d           = jp1;
        state_d       = S_SORT_CHK;
      end
      S_REV_CHK: begin
        if (i_q >= j_q) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = i_q[AW-1:0];
          state_d       = S_REV_RB;
        end
      end
      S_REV_RB: begin
        cmd_o.cap_a   = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = j_q[AW-1:0];
        state_d       = S_REV_W1;
      end
      S_REV_W1: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = i_q[AW-1:0];
        cmd_o.wr_sel  = WS_RDATA;
        state_d       = S_REV_W2;
      end
      S_REV_W2: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = j_q[AW-1:0];
        cmd_o.wr_sel  = WS_HOLD;
        i_d           = ip1;
        j_d           = j_q - 1'b1;
        state_d       = S_REV_CHK;
      end
      S_DMP_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = i_q[AW-1:0];
        state_d       = S_DMP_OUT;
      end
      S_DMP_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.st      = ST_OK;
          cmd_o.idx     = IDX_W'(i_q);
          cmd_o.elem_rd = 1'b1;
          cmd_o.last    = (ip1 == stat_i.cnt);
          if (ip1 == stat_i.cnt) begin
            state_d = S_IDLE;
          end else begin
            i_d     = ip1;
            state_d = S_DMP_RD;
          end
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.st   = st_q;
          cmd_o.idx  = idx_q;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      lim_q   <= '0;
      st_q    <= ST_OK;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      lim_q   <= lim_d;
      st_q    <= st_d;
      idx_q   <= idx_d;
    end
  end

  `SLE_ASSERT_IMPL(a_idle_quiet, state_q == S_IDLE,
                   !cmd_o.wr_en && cmd_o.cnt_op == CO_NONE && !cmd_o.emit)
  `SLE_ASSERT_IMPL(a_take_idle, cmd_o.take, state_q == S_IDLE)
  `SLE_ASSERT(a_ptr_bound, i_q <= CW'(DEPTH) && j_q <= CW'(DEPTH))

endmodule

>>> hdl/sequential_list_engine.sv
// append, drop last and clear pass through the idle, dispatch and done states; shifts and searches
// walk the entries with a read state and a write or compare state each; dump reads each entry, then
// emits its beat, held while the output is stalled; sort runs bubble passes of read, compare and swap
// one command at a time: the element memory (one read, one write port) and the control fsm set the rate
// reset: asynchronous active low, clears count, fsm and output valid; the element memory is not
// cleared and needs no clearing pass
module sequential_list_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sle_pkg::FUNC_W-1:0]       func_i,
  input  logic [sle_pkg::POS_W-1:0]        pos_i,
  input  logic signed [sle_pkg::VAL_W-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sle_pkg::ST_W-1:0]         status_o,
  output logic [sle_pkg::IDX_W-1:0]        index_o,
  output logic signed [sle_pkg::VAL_W-1:0] element_o,
  output logic [sle_pkg::CNT_W-1:0]        count_o,
  output logic                             last_o
);
  import sle_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sle_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  sle_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .pos_i       (pos_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .index_o     (index_o),
    .element_o   (element_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

  assign in_stall_o = !cmd.take;

endmodule
